FILE: rtl/core/sitl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sitl_pkg;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK               = 2'd0,
		ST_END_BEFORE_START = 2'd1,
		ST_OUT_OF_ORDER     = 2'd2,
		ST_TABLE_FULL       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_FINAL,
		BK_RESULT
	} back_state_t;

	localparam int STATUS_W    = 2;
	localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

FILE: rtl/core/sitl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sitl_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/sitl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sitl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sitl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sitl_front #(
	parameter int MAX_RANGES = 64,
	parameter int DAY_BITS   = 20,
	localparam int CW = $clog2(MAX_RANGES + 1),
	localparam int EW = 1 + 2 * DAY_BITS + sitl_pkg::STATUS_W + CW + DAY_BITS + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                cmd,
	input  logic [DAY_BITS-1:0] first_day,
	input  logic [DAY_BITS-1:0] last_day,
	input  logic                cq_full,
	output logic                cq_push,
	output logic [EW-1:0]       cq_data
);

	import sitl_pkg::*;

	logic [CW-1:0]       count_q;
	logic [DAY_BITS-1:0] last_start_q;
	logic [DAY_BITS:0]   widest_q;
	logic                accept;
	logic                is_append;
	status_t             st;
	logic [DAY_BITS:0]   width;
	logic [DAY_BITS:0]   widest_nxt;
	logic                grow;

	assign accept    = push && !cq_full;
	assign is_append = (cmd_t'(cmd) == CMD_APPEND);
	assign cq_push   = accept;

	always_comb begin
		if (!is_append) begin
			st = ST_OK;
		end else if (last_day < first_day) begin
			st = ST_END_BEFORE_START;
		end else if ((count_q != '0) && (first_day <= last_start_q)) begin
			st = ST_OUT_OF_ORDER;
		end else if (count_q >= CW'(MAX_RANGES)) begin
			st = ST_TABLE_FULL;
		end else begin
			st = ST_OK;
		end
	end

	assign width      = {1'b0, last_day} - {1'b0, first_day} + (DAY_BITS + 1)'(1);
	assign grow       = is_append && (st == ST_OK);
	assign widest_nxt = (grow && (width > widest_q)) ? width : widest_q;

	// count is the table size seen by this item, before any append it makes
	assign cq_data = {cmd, first_day, last_day, st, count_q, widest_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			last_start_q <= '0;
			widest_q     <= '0;
		end else if (accept && grow) begin
			count_q      <= count_q + CW'(1);
			last_start_q <= first_day;
			widest_q     <= widest_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sitl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sitl_back #(
	parameter int MAX_RANGES = 64,
	parameter int DAY_BITS   = 20,
	localparam int CW = $clog2(MAX_RANGES + 1),
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
	localparam int EW = 1 + 2 * DAY_BITS + sitl_pkg::STATUS_W + CW + DAY_BITS + 1,
	localparam int RW = sitl_pkg::STATUS_W + 1 + 3 * DAY_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cq_empty,
	input  logic [EW-1:0]         cq_data,
	output logic                  cq_pop,
	input  logic                  rq_full,
	output logic                  rq_push,
	output logic [RW-1:0]         rq_data,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [2*DAY_BITS-1:0] ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr,
	input  logic [2*DAY_BITS-1:0] ram_rdata
);

	import sitl_pkg::*;

	back_state_t state_q, state_d;

	logic                h_op;
	logic [DAY_BITS-1:0] h_first;
	logic [DAY_BITS-1:0] h_last;
	logic [STATUS_W-1:0] h_status;
	logic [CW-1:0]       h_count;
	logic [DAY_BITS:0]   h_widest;
	logic                h_query;
	logic [CW-1:0]       h_step;

	logic [DAY_BITS-1:0] day_q;
	logic [STATUS_W-1:0] status_q;
	logic [DAY_BITS:0]   widest_q;
	logic [CW-1:0]       cnt0_q;
	logic [CW-1:0]       first_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       probe_q;
	logic                res_active_q;
	logic [DAY_BITS-1:0] res_ws_q;
	logic [DAY_BITS-1:0] res_we_q;

	logic [DAY_BITS-1:0] rd_start;
	logic [DAY_BITS-1:0] rd_end;
	logic [CW-1:0]       step;
	logic                less;
	logic [CW-1:0]       nf;
	logic [CW-1:0]       nc;
	logic [CW-1:0]       nprobe;
	logic                hit;

	assign {h_op, h_first, h_last, h_status, h_count, h_widest} = cq_data;
	assign h_query = (cmd_t'(h_op) == CMD_QUERY);
	assign h_step  = h_count >> 1;

	assign {rd_start, rd_end} = ram_rdata;

	// one lower-bound halving step per cycle on the entry read last cycle
	assign step   = cnt_q >> 1;
	assign less   = rd_end < day_q;
	assign nf     = less ? probe_q + CW'(1) : first_q;
	assign nc     = less ? cnt_q - step - CW'(1) : step;
	assign nprobe = nf + (nc >> 1);
	assign hit    = (first_q < cnt0_q) && (rd_start <= day_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!cq_empty) begin
					if (!h_query) begin
						state_d = BK_RESULT;
					end else if (h_count == '0) begin
						state_d = BK_FINAL;
					end else begin
						state_d = BK_SEARCH;
					end
				end
			end
			BK_SEARCH: begin
				if (nc == '0) begin
					state_d = BK_FINAL;
				end
			end
			BK_FINAL: begin
				state_d = BK_RESULT;
			end
			BK_RESULT: begin
				if (!rq_full) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cq_pop    = 1'b0;
		rq_push   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			BK_IDLE: begin
				cq_pop    = !cq_empty;
				ram_we    = !cq_empty && !h_query && (status_t'(h_status) == ST_OK);
				ram_re    = !cq_empty && h_query;
				ram_raddr = h_step[AW-1:0];
			end
			BK_SEARCH: begin
				ram_re    = 1'b1;
				ram_raddr = nprobe[AW-1:0];
			end
			BK_FINAL: begin
			end
			BK_RESULT: begin
				rq_push = !rq_full;
			end
			default: begin
			end
		endcase
	end

	assign ram_waddr = h_count[AW-1:0];
	assign ram_wdata = {h_first, h_last};
	assign rq_data   = {status_q, res_active_q, res_ws_q, res_we_q, widest_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!cq_empty) begin
					day_q        <= h_first;
					status_q     <= h_status;
					widest_q     <= h_widest;
					cnt0_q       <= h_count;
					first_q      <= '0;
					cnt_q        <= h_count;
					probe_q      <= h_step;
					res_active_q <= 1'b0;
					res_ws_q     <= '0;
					res_we_q     <= '0;
				end
			end
			BK_SEARCH: begin
				first_q <= nf;
				cnt_q   <= nc;
				probe_q <= nprobe;
			end
			BK_FINAL: begin
				res_active_q <= hit;
				res_ws_q     <= hit ? rd_start : '0;
				res_we_q     <= hit ? rd_end : '0;
			end
			BK_RESULT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_interval_table_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake       Transfer when    Payload
// input     push / full     push && !full    cmd, first_day, last_day
// result    empty / pop     pop && !empty    status, is_active, window_start,
//                                            window_end, widest_window
//
// Append: the table write happens on the pop, then the result is offered. Query: a
// lower-bound search over the stored ranges, one halving step per table RAM read,
// a final hit check, then the result. Front end checks appends and tracks count
// and widest range at one item per cycle while the command queue is not full.
// Two-entry queues sit before and after the back end; a stalled result side fills
// them, then full rises. Reset clears counts, queues and state; the table RAM is not cleared.

module sorted_interval_table_lookup_top #(
	parameter int MAX_RANGES = 64,
	parameter int DAY_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic [DAY_BITS-1:0]           first_day,
	input  logic [DAY_BITS-1:0]           last_day,
	output logic                          empty,
	input  logic                          pop,
	output logic [sitl_pkg::STATUS_W-1:0] status,
	output logic                          is_active,
	output logic [DAY_BITS-1:0]           window_start,
	output logic [DAY_BITS-1:0]           window_end,
	output logic [DAY_BITS:0]             widest_window
);

	import sitl_pkg::*;

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int EW = 1 + 2 * DAY_BITS + STATUS_W + CW + DAY_BITS + 1;
	localparam int RW = STATUS_W + 1 + 3 * DAY_BITS + 1;

	logic                  cq_push;
	logic [EW-1:0]         cq_din;
	logic                  cq_full;
	logic                  cq_pop;
	logic [EW-1:0]         cq_dout;
	logic                  cq_empty;
	logic                  rq_push;
	logic [RW-1:0]         rq_din;
	logic                  rq_full;
	logic [RW-1:0]         rq_dout;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [2*DAY_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [2*DAY_BITS-1:0] ram_rdata;

	assign full = cq_full;

	sitl_front #(
		.MAX_RANGES(MAX_RANGES),
		.DAY_BITS  (DAY_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd      (cmd),
		.first_day(first_day),
		.last_day (last_day),
		.cq_full  (cq_full),
		.cq_push  (cq_push),
		.cq_data  (cq_din)
	);

	sitl_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.din   (cq_din),
		.full  (cq_full),
		.pop   (cq_pop),
		.dout  (cq_dout),
		.empty (cq_empty)
	);

	sitl_ram #(
		.WIDTH(2 * DAY_BITS),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sitl_back #(
		.MAX_RANGES(MAX_RANGES),
		.DAY_BITS  (DAY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_empty (cq_empty),
		.cq_data  (cq_dout),
		.cq_pop   (cq_pop),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_data  (rq_din),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	sitl_fifo #(
		.WIDTH(RW),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.din   (rq_din),
		.full  (rq_full),
		.pop   (pop),
		.dout  (rq_dout),
		.empty (empty)
	);

	assign {status, is_active, window_start, window_end, widest_window} = rq_dout;

	// back end never pops commands in consecutive cycles
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |=> !cq_pop)
		else $error("back end popped commands in consecutive cycles");

	a_push_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |=> !rq_push)
		else $error("back end pushed results in consecutive cycles");

	a_write_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !ram_we && !ram_re)
		else $error("table access right after an append write");

	a_write_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> cq_pop && !ram_re)
		else $error("table write without a command transfer");

endmodule

`default_nettype wire
